@@ rtl/irru_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irru_pkg
// Payload types and command / status codes for the inverse row update block.
// ----------------------------------------------------------------------------
package irru_pkg;

   localparam int unsigned IdxWidth  = 3;
   localparam int unsigned DataWidth = 32;

   typedef enum logic [1:0] {
      CMD_WRITE_INV = 2'd0,
      CMD_WRITE_ROW = 2'd1,
      CMD_UPDATE    = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_RATIO = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                      cmd;
      logic [IdxWidth-1:0]          row_index;
      logic [IdxWidth-1:0]          col_index;
      logic signed [DataWidth-1:0]  element_value;
      logic signed [DataWidth-1:0]  ratio;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0]  read_value;
      status_type                   status;
   } rsp_type;

   // request from sequencer to divider
   typedef struct packed {
      logic                         start;
      logic signed [63:0]           dividend;
      logic signed [DataWidth-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [63:0]           quotient;
   } div_rsp_type;

   // saturate a 64-bit value to 32 bits, flagging a clip in the top bit
   function automatic logic [DataWidth:0] sat32(input logic signed [63:0] v);
      logic [DataWidth:0] r;
      if (v > 64'sd2147483647)        r = {1'b1, 32'h7FFF_FFFF};
      else if (v < -64'sd2147483648)  r = {1'b1, 32'h8000_0000};
      else                            r = {1'b0, v[31:0]};
      return r;
   endfunction

endpackage : irru_pkg
`default_nettype wire

@@ rtl/irru_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irru_div
// Signed restoring divider, one quotient bit a cycle, truncating to zero.
// ----------------------------------------------------------------------------
module irru_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire irru_pkg::div_req_type div_req,
   output irru_pkg::div_rsp_type      div_rsp
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[62:0], quo_ff[63]};
      trial   = {1'b0, shifted} - {33'd0, dvs_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend[63] ? 64'(-div_req.dividend) : div_req.dividend;
         dvs_in  = div_req.divisor[31] ? 32'(-div_req.divisor) : div_req.divisor;
         neg_in  = div_req.dividend[63] ^ div_req.divisor[31];
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? 64'(-quo_ff) : quo_ff;

endmodule : irru_div
`default_nettype wire

@@ rtl/inverse_row_replace_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_row_replace_update
// Holds a matrix inverse in a RAM and applies Sherman-Morrison row updates.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_ready  | irru_pkg::req_type
//  rsp_    | out | rsp_valid/rsp_ready  | irru_pkg::rsp_type
//
// Write: an accepted beat passes READ and RESP into the output register; read
//   adds DOT_END for the registered RAM read. A new beat is taken only in IDLE.
// Update: a dot phase of N*N products (DOT, then DOT_ACC for each), then per row
//   one RAM read, a wait on the divider and N read-modify-write passes (ROW_RD,
//   ROW_MUL, ROW_WR); its run time is set by the divider and the RAM accesses.
// Reset clears control only; RAM contents stay undefined until written.
// A full output register stalls the sequencer; no new beat is taken meanwhile.
// ----------------------------------------------------------------------------
module inverse_row_replace_update #(
   parameter int unsigned MATRIX_DIM = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire irru_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      irru_pkg::rsp_type rsp_data
);

   localparam int unsigned DimW  = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
   localparam int unsigned Depth = MATRIX_DIM * MATRIX_DIM;
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam logic [DimW-1:0] LastIdx = DimW'(MATRIX_DIM - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_DOT, ST_DOT_ACC, ST_DOT_END, ST_FREAD, ST_FDIV,
      ST_FWAIT, ST_ROW_RD, ST_ROW_MUL, ST_ROW_WR, ST_RESP
   } state_type;

   state_type state_ff;

   // main memories
   logic signed [31:0] inv_mem [Depth];
   logic signed [31:0] row_mem [MATRIX_DIM];
   logic signed [63:0] dot_mem [MATRIX_DIM];

   logic               inv_we;
   logic [AddrW-1:0]   inv_waddr, inv_raddr;
   logic signed [31:0] inv_wdata, inv_rdata_ff;
   logic signed [31:0] row_rdata_ff;
   logic               re;
   logic [DimW-1:0]    row_raddr;

   irru_pkg::req_type  req_ff;
   logic [DimW-1:0]    k_ff, j_ff, l_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] f_ff;
   logic signed [63:0] prod_ff;
   logic               clip_ff;
   logic signed [31:0] rdval_ff;
   irru_pkg::status_type st_ff;
   logic               rsp_valid_ff;
   irru_pkg::rsp_type  rsp_ff;
   irru_pkg::div_req_type div_req;
   irru_pkg::div_rsp_type div_rsp;

   logic signed [31:0] dsat_ff [MATRIX_DIM];
   logic signed [31:0] rowbuf_ff [MATRIX_DIM];

   logic               row_ok, col_ok;
   logic [DimW-1:0]    ti;
   logic [32:0]        sat_q, sat_e, sat_d;
   logic signed [63:0] diff;
   logic signed [63:0] dprod;

   assign row_ok = (MATRIX_DIM >= 8) || (32'(req_ff.row_index) < MATRIX_DIM);
   assign col_ok = (MATRIX_DIM >= 8) || (32'(req_ff.col_index) < MATRIX_DIM);
   assign ti     = DimW'(req_ff.row_index);

   function automatic logic [AddrW-1:0] addr(input logic [DimW-1:0] r,
                                              input logic [DimW-1:0] c);
      return AddrW'(32'(r) * MATRIX_DIM + 32'(c));
   endfunction

   always_ff @(posedge clock) begin
      if (inv_we) inv_mem[inv_waddr] <= inv_wdata;
      if (re) begin
         inv_rdata_ff <= inv_mem[inv_raddr];
         row_rdata_ff <= row_mem[row_raddr];
      end
   end

   assign sat_q = irru_pkg::sat32(div_rsp.quotient);
   assign dprod = 64'(f_ff) * 64'(dsat_ff[j_ff]);
   // old element arrives from the RAM in ROW_MUL
   assign diff  = 64'(inv_rdata_ff) - (prod_ff >>> 24);
   assign sat_e = irru_pkg::sat32(diff);
   assign sat_d = irru_pkg::sat32(acc_ff);

   irru_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   always_comb begin
      inv_we    = 1'b0;
      inv_waddr = addr(DimW'(req_ff.row_index), DimW'(req_ff.col_index));
      inv_wdata = req_ff.element_value;
      inv_raddr = addr(DimW'(req_ff.row_index), DimW'(req_ff.col_index));
      row_raddr = l_ff;
      re        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = 64'(inv_rdata_ff) <<< 24;
      div_req.divisor  = req_ff.ratio;
      unique case (state_ff)
         ST_READ: begin
            re = 1'b1;
            if (req_ff.cmd == irru_pkg::CMD_WRITE_INV) inv_we = row_ok && col_ok;
         end
         ST_DOT: begin
            re = 1'b1;
            inv_raddr = addr(l_ff, j_ff);
         end
         ST_FREAD: begin
            re = 1'b1;
            inv_raddr = addr(k_ff, ti);
         end
         ST_FDIV:  div_req.start = 1'b1;
         ST_ROW_RD: begin
            re = 1'b1;
            inv_raddr = addr(k_ff, j_ff);
         end
         ST_ROW_WR: begin
            inv_we    = 1'b1;
            inv_waddr = addr(k_ff, j_ff);
            inv_wdata = rowbuf_ff[j_ff];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               req_ff   <= req_data;
               clip_ff  <= 1'b0;
               j_ff     <= '0;
               l_ff     <= '0;
               k_ff     <= '0;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               rdval_ff <= '0;
               unique case (req_ff.cmd)
                  irru_pkg::CMD_WRITE_INV: begin
                     st_ff    <= irru_pkg::STATUS_OK;
                     state_ff <= ST_RESP;
                  end
                  irru_pkg::CMD_WRITE_ROW: begin
                     if (col_ok) row_mem[DimW'(req_ff.col_index)] <= req_ff.element_value;
                     st_ff    <= irru_pkg::STATUS_OK;
                     state_ff <= ST_RESP;
                  end
                  irru_pkg::CMD_READ: begin
                     st_ff    <= irru_pkg::STATUS_OK;
                     state_ff <= ST_DOT_END; // wait for RAM data
                  end
                  irru_pkg::CMD_UPDATE: begin
                     if (row_ok && req_ff.ratio != '0) begin
                        st_ff    <= irru_pkg::STATUS_OK;
                        acc_ff   <= '0;
                        state_ff <= ST_DOT;
                     end else begin
                        st_ff    <= row_ok ? irru_pkg::STATUS_ZERO_RATIO
                                           : irru_pkg::STATUS_OK;
                        state_ff <= ST_RESP;
                     end
                  end
               endcase
            end
            ST_DOT: state_ff <= ST_DOT_ACC;
            ST_DOT_ACC: begin
               acc_ff <= acc_ff + ((64'(row_rdata_ff) * 64'(inv_rdata_ff)) >>> 24);
               if (l_ff == LastIdx) state_ff <= ST_DOT_END;
               else begin
                  l_ff     <= l_ff + 1'b1;
                  state_ff <= ST_DOT;
               end
            end
            ST_DOT_END: begin
               if (req_ff.cmd == irru_pkg::CMD_READ) begin
                  rdval_ff <= (row_ok && col_ok) ? inv_rdata_ff : '0;
                  state_ff <= ST_RESP;
               end else begin
                  dot_mem[j_ff] <= acc_ff;
                  dsat_ff[j_ff] <= sat_d[31:0];
                  clip_ff  <= clip_ff | sat_d[32];
                  acc_ff   <= '0;
                  l_ff     <= '0;
                  if (j_ff == LastIdx) begin
                     j_ff     <= '0;
                     state_ff <= ST_FREAD;
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_DOT;
                  end
               end
            end
            ST_FREAD: state_ff <= ST_FDIV;
            ST_FDIV:  state_ff <= ST_FWAIT;
            ST_FWAIT: if (div_rsp.done) begin
               f_ff     <= sat_q[31:0];
               clip_ff  <= clip_ff | sat_q[32];
               j_ff     <= '0;
               state_ff <= ST_ROW_RD;
            end
            ST_ROW_RD: begin
               prod_ff  <= dprod;
               state_ff <= ST_ROW_MUL;
            end
            ST_ROW_MUL: begin
               if (j_ff == ti) rowbuf_ff[j_ff] <= f_ff;
               else begin
                  rowbuf_ff[j_ff] <= sat_e[31:0];
                  clip_ff         <= clip_ff | sat_e[32];
               end
               state_ff <= ST_ROW_WR;
            end
            ST_ROW_WR: begin
               if (j_ff == LastIdx) begin
                  j_ff <= '0;
                  if (k_ff == LastIdx) begin
                     st_ff    <= (clip_ff) ? irru_pkg::STATUS_SATURATED : irru_pkg::STATUS_OK;
                     state_ff <= ST_RESP;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_FREAD;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_ROW_RD;
               end
            end
            ST_RESP: if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff.read_value <= rdval_ff;
               rsp_ff.status     <= st_ff;
               state_ff          <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second beat while busy");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_FWAIT)
      else $error("divider finished outside wait state");

endmodule : inverse_row_replace_update
`default_nettype wire

@@ bench/inverse_row_replace_update_tb.sv @@
// ----------------------------------------------------------------------------
// inverse_row_replace_update_tb
// Self-checking bench for the Sherman-Morrison row update block. A
// cycle-free predictor mirrors the inverse store, the new-row buffer and the
// update arithmetic. Every request beat is predicted as it is accepted, and
// every response beat is checked in order against the predicted queue. The
// sender bursts with gaps, and the receiver stalls, including one long
// hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module inverse_row_replace_update_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Dim       = 8;
   localparam int unsigned CycleLimit = 1_000_000;
   localparam longint     QOne      = 64'sd16777216;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   irru_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   irru_pkg::rsp_type rsp_data;

   inverse_row_replace_update #(.MATRIX_DIM(Dim)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // predictor state
   longint  inv_mem [Dim*Dim];
   longint  row_mem [Dim];
   longint  dot_sums [Dim];
   irru_pkg::rsp_type rsp_expected [$];
   int      errors = 0;
   int      cycles = 0;

   // sender pacing
   int      burst_left = 0;
   bit      no_gaps = 1'b0;

   // receiver stall pattern and long hold-off
   bit      hold_go = 1'b0;
   int      hold_left = 0;
   int      stall_mode = 0;
   int      mode_left = 0;

   function automatic longint floor_q(input longint v);
      return v >>> 24;
   endfunction

   function automatic longint clip32(input longint v, inout bit clipped);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic irru_pkg::rsp_type predict_response(input irru_pkg::req_type rq);
      irru_pkg::rsp_type r;
      longint  dsat [Dim];
      longint  rowbuf [Dim];
      longint  acc;
      longint  f;
      longint  rt;
      bit      clipped;
      int      ti;
      r.read_value = '0;
      r.status = irru_pkg::STATUS_OK;
      clipped = 1'b0;
      ti = rq.row_index;
      rt = longint'(rq.ratio);
      case (rq.cmd)
         irru_pkg::CMD_WRITE_INV: inv_mem[rq.row_index*Dim + rq.col_index] = rq.element_value;
         irru_pkg::CMD_WRITE_ROW: row_mem[rq.col_index] = rq.element_value;
         irru_pkg::CMD_READ: r.read_value = inv_mem[rq.row_index*Dim + rq.col_index][31:0];
         default: begin
            if (rt == 0) begin
               r.status = irru_pkg::STATUS_ZERO_RATIO;
            end else begin
               for (int j = 0; j < Dim; j++) begin
                  acc = 0;
                  for (int l = 0; l < Dim; l++)
                     acc += floor_q(row_mem[l] * inv_mem[l*Dim + j]);
                  dot_sums[j] = acc;
                  dsat[j] = clip32(acc, clipped);
               end
               for (int k = 0; k < Dim; k++) begin
                  f = clip32((inv_mem[k*Dim + ti] * QOne) / rt, clipped);
                  for (int j = 0; j < Dim; j++)
                     rowbuf[j] = (j == ti) ? f :
                        clip32(inv_mem[k*Dim + j] - floor_q(f * dsat[j]), clipped);
                  for (int j = 0; j < Dim; j++)
                     inv_mem[k*Dim + j] = rowbuf[j];
               end
               if (clipped) r.status = irru_pkg::STATUS_SATURATED;
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
         3, 4: return $urandom();
         default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      endcase
   endfunction

   function automatic logic [31:0] rand_ratio();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h0100_0000;
         2: return 32'hFF00_0000;
         3: return $urandom();
         default: return rand_value();
      endcase
   endfunction

   function automatic irru_pkg::req_type make_req(input irru_pkg::cmd_type c, input int r,
                                                  input int col, input logic [31:0] v,
                                                  input logic [31:0] rt);
      irru_pkg::req_type q;
      q.cmd = c;
      q.row_index = r[2:0];
      q.col_index = col[2:0];
      q.element_value = v;
      q.ratio = rt;
      return q;
   endfunction

   // one request beat; predicted at the edge where it is accepted
   task automatic send_beat(input irru_pkg::req_type q);
      int gap;
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      rsp_expected.push_back(predict_response(q));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_random_beat();
      irru_pkg::req_type q;
      q = make_req(irru_pkg::cmd_type'($urandom_range(0, 3)), $urandom_range(0, 7),
                   $urandom_range(0, 7), rand_value(), rand_ratio());
      // keep updates rare, they are long
      if (q.cmd == irru_pkg::CMD_UPDATE && $urandom_range(0, 5) != 0)
         q.cmd = irru_pkg::CMD_READ;
      send_beat(q);
   endtask

   task automatic test_load_all();
      for (int r = 0; r < Dim; r++)
         for (int c = 0; c < Dim; c++)
            send_beat(make_req(irru_pkg::CMD_WRITE_INV, r, c,
                               (r == c) ? 32'h0100_0000 : 32'h0, 0));
      for (int c = 0; c < Dim; c++)
         send_beat(make_req(irru_pkg::CMD_WRITE_ROW, 0, c,
                            (c == 3) ? 32'h0200_0000 : 32'h0, 0));
   endtask

   task automatic test_directed();
      send_beat(make_req(irru_pkg::CMD_UPDATE, 3, 0, 0, 32'h0));           // zero ratio
      send_beat(make_req(irru_pkg::CMD_UPDATE, 3, 0, 0, 32'h0100_0000));
      send_beat(make_req(irru_pkg::CMD_READ, 3, 3, 0, 0));
      send_beat(make_req(irru_pkg::CMD_READ, 0, 0, 0, 0));
      send_beat(make_req(irru_pkg::CMD_WRITE_INV, 7, 7, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_beat(make_req(irru_pkg::CMD_WRITE_INV, 0, 7, 32'h8000_0000, 32'h8000_0000));
      send_beat(make_req(irru_pkg::CMD_WRITE_ROW, 7, 7, 32'h7FFF_FFFF, 0));
      send_beat(make_req(irru_pkg::CMD_WRITE_ROW, 7, 0, 32'h8000_0000, 0));
      send_beat(make_req(irru_pkg::CMD_READ, 7, 7, 0, 0));
      send_beat(make_req(irru_pkg::CMD_READ, 0, 7, 0, 0));
      // saturating update, then divisor extremes
      send_beat(make_req(irru_pkg::CMD_UPDATE, 7, 0, 0, 32'h0000_0001));
      send_beat(make_req(irru_pkg::CMD_UPDATE, 0, 0, 0, 32'h8000_0000));
      send_beat(make_req(irru_pkg::CMD_UPDATE, 5, 0, 0, 32'h7FFF_FFFF));
      send_beat(make_req(irru_pkg::CMD_READ, 7, 0, 0, 0));
      send_beat(make_req(irru_pkg::CMD_READ, 0, 5, 0, 0));
   endtask

   task automatic test_backpressure();
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      no_gaps = 1'b1;
      for (int n = 0; n < 40; n++)
         send_beat(make_req(irru_pkg::CMD_READ, $urandom_range(0, 7),
                            $urandom_range(0, 7), 0, 0));
      no_gaps = 1'b0;
   endtask

   task automatic test_random();
      for (int n = 0; n < 560; n++) begin
         no_gaps = (n / 200) % 2 == 1;
         if ($urandom_range(0, 15) == 0) begin
            // well-formed update: fresh row, apply, read back some entries
            for (int c = 0; c < Dim; c++)
               send_beat(make_req(irru_pkg::CMD_WRITE_ROW, $urandom_range(0, 7), c,
                                  rand_value(), 0));
            send_beat(make_req(irru_pkg::CMD_UPDATE, $urandom_range(0, 7),
                               $urandom_range(0, 7), $urandom(), rand_ratio()));
            repeat (4)
               send_beat(make_req(irru_pkg::CMD_READ, $urandom_range(0, 7),
                                  $urandom_range(0, 7), $urandom(), $urandom()));
         end else begin
            send_random_beat();
         end
      end
   endtask

   // response checker and ready driver
   always @(posedge clock) begin
      irru_pkg::rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response beat, actual %h", $realtime, rsp_data);
            errors++;
         end else begin
            want = rsp_expected.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $realtime,
                        want.read_value, rsp_data.read_value);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_data.status);
               errors++;
            end
         end
      end
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      if (reset || hold_left != 0)
         rsp_ready <= 1'b0;
      else if (stall_mode == 0)
         rsp_ready <= 1'b1;
      else if (stall_mode == 1)
         rsp_ready <= $urandom_range(0, 3) != 0;
      else
         rsp_ready <= $urandom_range(0, 1) != 0;
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_go && hold_left == 0) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_all();
      test_directed();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
